>>> src/early_reflection_tapped_delay_defines.svh
// assertion macros for the early reflection tapped delay
`ifndef EARLY_REFLECTION_TAPPED_DELAY_DEFINES_SVH
`define EARLY_REFLECTION_TAPPED_DELAY_DEFINES_SVH

// checked only outside reset
`define ERD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ERD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> src/erd_pkg.sv
package erd_pkg;

    localparam int unsigned TAP_COUNT = 19;
    localparam int unsigned TAP_W     = 5;
    localparam int unsigned SAMPLE_W  = 16;
    localparam int unsigned GAIN_W    = 17;
    localparam int unsigned PROD_W    = SAMPLE_W + GAIN_W;
    localparam int unsigned ACC_W     = 40;
    localparam int unsigned FRAC_W    = 15;

    localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(TAP_COUNT - 1);

    // reflection times in units of 10 us
    localparam int unsigned TAP_TIME [TAP_COUNT] = '{
        0, 1277, 1283, 1293, 1333, 1566, 2404, 2679, 2731, 2737,
        2914, 2920, 2981, 3389, 4518, 4522, 4527, 5452, 6958
    };

    // tap gains, signed Q2.15
    localparam logic signed [GAIN_W-1:0] TAP_GAIN [TAP_COUNT] = '{
        17'sd32768, 17'sd5000, -17'sd13425, 17'sd9778, 17'sd5089,
        17'sd4725, -17'sd10237, -17'sd13684, -17'sd30772, 17'sd22695,
        -17'sd18963, 17'sd18946, 17'sd13782, 17'sd12970, 17'sd11305,
        -17'sd17567, 17'sd13664, 17'sd6383, 17'sd5072
    };

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    // per-read control travelling alongside the memory read
    typedef struct packed {
        logic             vld;
        logic             first;
        logic             last;
        logic             hit;
        logic [TAP_W-1:0] tap;
    } t_mac_ctrl;

endpackage

>>> src/erd_mem.sv
module erd_mem #(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned AW    = 12
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic                           i_we,
    input  logic [AW-1:0]                  i_addr,
    input  logic [erd_pkg::SAMPLE_W-1:0]   i_wdata,
    output logic [erd_pkg::SAMPLE_W-1:0]   o_rdata
);

    logic [erd_pkg::SAMPLE_W-1:0] r_mem [DEPTH];
    logic [erd_pkg::SAMPLE_W-1:0] r_rdata;

    // single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/erd_mac.sv
module erd_mac (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  erd_pkg::t_mac_ctrl                   i_ctrl,
    input  logic signed [erd_pkg::SAMPLE_W-1:0]  i_rdata,
    output logic                                 o_done,
    output logic signed [erd_pkg::SAMPLE_W-1:0]  o_result
);

    localparam int unsigned SHIFT_W = erd_pkg::ACC_W - erd_pkg::FRAC_W;

    erd_pkg::t_mac_ctrl                      r_c1;
    erd_pkg::t_mac_ctrl                      r_c2;
    logic signed [erd_pkg::PROD_W-1:0]       r_prod;
    logic signed [erd_pkg::ACC_W-1:0]        r_acc;
    logic                                    r_done;

    logic signed [erd_pkg::SAMPLE_W-1:0]     w_data;
    logic signed [erd_pkg::PROD_W-1:0]       w_prod;
    logic signed [erd_pkg::ACC_W-1:0]        w_round;
    logic signed [SHIFT_W-1:0]               w_shift;

    // control follows the read data through the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1   <= '0;
            r_c2   <= '0;
            r_done <= 1'b0;
        end else begin
            r_c1   <= i_ctrl;
            r_c2   <= r_c1;
            r_done <= r_c2.vld && r_c2.last;
        end
    end

    // entries never written since reset read as zero
    assign w_data = r_c1.hit ? i_rdata : '0;
    assign w_prod = w_data * erd_pkg::TAP_GAIN[r_c1.tap];

    // multiply stage
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
    end

    // accumulate stage
    always_ff @(posedge i_clk) begin
        if (r_c2.vld) begin
            if (r_c2.first) begin
                r_acc <= erd_pkg::ACC_W'(r_prod);
            end else begin
                r_acc <= r_acc + erd_pkg::ACC_W'(r_prod);
            end
        end
    end

    // round to nearest (half up) and saturate
    assign w_round = r_acc + erd_pkg::ACC_W'(signed'(41'sd16384));
    assign w_shift = SHIFT_W'(w_round >>> erd_pkg::FRAC_W);

    always_comb begin
        priority if (w_shift > SHIFT_W'(signed'(33'sd32767))) begin
            o_result = 16'sh7FFF;
        end else if (w_shift < -SHIFT_W'(signed'(33'sd32768))) begin
            o_result = 16'sh8000;
        end else begin
            o_result = w_shift[erd_pkg::SAMPLE_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

>>> src/early_reflection_tapped_delay.sv
// flow: each input beat is written to the delay memory, then the 19 tap reads are multiplied,
// accumulated, handed on by the done signal and placed in the output register
// throughput: one sample at a time; a new sample is taken only once the last result is in the
// output register, set by the single memory port (1 write + 19 reads) and the pipe behind it
// reset: synchronous active low, clears control, write pointer and fill count
// the delay memory is not cleared; taps older than the fill count read as zero
module early_reflection_tapped_delay #(
    parameter int unsigned DELAY_DEPTH = 4096,
    parameter int unsigned SAMPLE_RATE = 48000
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [15:0]                  i_sample_in,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [15:0]                  o_reflection_out
);

    localparam int unsigned AW = $clog2(DELAY_DEPTH);

    erd_pkg::t_state                      r_state, n_state;
    logic [erd_pkg::TAP_W-1:0]            r_tap, n_tap;
    logic [AW-1:0]                        r_wp, n_wp;
    logic [AW:0]                          r_fill, n_fill;
    logic                                 r_out_vld, n_out_vld;
    logic signed [15:0]                   r_out_data, n_out_data;

    logic [AW-1:0]                        w_tap_delay [erd_pkg::TAP_COUNT];
    logic [AW-1:0]                        w_dly;
    logic [AW:0]                          w_sub;
    logic [AW-1:0]                        w_rd_addr;
    logic                                 w_accept;
    logic                                 w_mem_en;
    logic [AW-1:0]                        w_mem_addr;
    logic [erd_pkg::SAMPLE_W-1:0]         w_rdata;
    erd_pkg::t_mac_ctrl                   w_ctrl;
    logic                                 w_mac_done;
    logic signed [erd_pkg::SAMPLE_W-1:0]  w_mac_result;

    // tap delays in samples, fixed at elaboration
    for (genvar k = 0; k < erd_pkg::TAP_COUNT; k++) begin : g_dly
        localparam longint DRAW =
            (longint'(SAMPLE_RATE) * longint'(erd_pkg::TAP_TIME[k]) + 50000) / 100000;
        localparam longint DSAT =
            (DRAW > longint'(DELAY_DEPTH - 1)) ? longint'(DELAY_DEPTH - 1) : DRAW;
        assign w_tap_delay[k] = AW'(DSAT);
    end

    assign w_accept = i_valid && o_ready;

    // read address: write pointer minus delay, wrapped
    assign w_dly     = w_tap_delay[r_tap];
    assign w_sub     = {1'b0, r_wp} - {1'b0, w_dly};
    assign w_rd_addr = w_sub[AW] ? AW'(w_sub + (AW+1)'(DELAY_DEPTH)) : w_sub[AW-1:0];

    // memory port: write on input beat, reads while sweeping taps
    assign w_mem_en   = w_accept || (r_state == erd_pkg::S_READ);
    assign w_mem_addr = w_accept ? r_wp : w_rd_addr;

    erd_mem #(
        .DEPTH (DELAY_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_en    (w_mem_en),
        .i_we    (w_accept),
        .i_addr  (w_mem_addr),
        .i_wdata (i_sample_in),
        .o_rdata (w_rdata)
    );

    // control for the read issued this cycle
    always_comb begin
        w_ctrl.vld   = (r_state == erd_pkg::S_READ);
        w_ctrl.first = (r_tap == '0);
        w_ctrl.last  = (r_tap == erd_pkg::TAP_LAST);
        w_ctrl.hit   = ({1'b0, w_dly} < r_fill);
        w_ctrl.tap   = r_tap;
    end

    erd_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_rdata  (w_rdata),
        .o_done   (w_mac_done),
        .o_result (w_mac_result)
    );

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_tap      = r_tap;
        n_wp       = r_wp;
        n_fill     = r_fill;
        n_out_vld  = r_out_vld;
        n_out_data = r_out_data;

        if (r_out_vld && i_ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            erd_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = erd_pkg::S_READ;
                    n_tap   = '0;
                    if (r_fill != (AW+1)'(DELAY_DEPTH)) begin
                        n_fill = r_fill + 1'b1;
                    end
                end
            end
            erd_pkg::S_READ: begin
                if (r_tap == erd_pkg::TAP_LAST) begin
                    n_state = erd_pkg::S_DRAIN;
                    n_tap   = '0;
                end else begin
                    n_tap = r_tap + 1'b1;
                end
            end
            erd_pkg::S_DRAIN: begin
                if (w_mac_done) begin
                    n_state = erd_pkg::S_DONE;
                end
            end
            erd_pkg::S_DONE: begin
                if (!r_out_vld || i_ready) begin
                    n_out_vld  = 1'b1;
                    n_out_data = w_mac_result;
                    n_state    = erd_pkg::S_IDLE;
                    n_wp       = (r_wp == AW'(DELAY_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                end
            end
            default: begin
                n_state = erd_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= erd_pkg::S_IDLE;
            r_tap     <= '0;
            r_wp      <= '0;
            r_fill    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_tap     <= n_tap;
            r_wp      <= n_wp;
            r_fill    <= n_fill;
            r_out_vld <= n_out_vld;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_ready          = (r_state == erd_pkg::S_IDLE);
    assign o_valid          = r_out_vld;
    assign o_reflection_out = r_out_data;

endmodule

>>> src/erd_chk.sv
`include "early_reflection_tapped_delay_defines.svh"

module erd_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [15:0] o_reflection_out
);

    // a stalled result beat holds
    `ERD_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid && $stable(o_reflection_out), "result changed while stalled")

    // one sample at a time: input closes after a beat
    `ERD_ASSERT(a_one_item, i_valid && o_ready |=> !o_ready, "input taken while busy")

    // a new result only appears while the input side is closed
    `ERD_ASSERT(a_new_result, $rose(o_valid) |-> !$past(o_ready), "result without a sample")

    // reset leaves the block empty and open for input
    `ERD_ASSERT_ALWAYS(a_reset, !i_rst_n |=> !o_valid && o_ready, "bad state after reset")

endmodule

bind early_reflection_tapped_delay erd_chk u_erd_chk (.*);

>>> bench/early_reflection_tapped_delay_tb.sv
module early_reflection_tapped_delay_tb;

    localparam int unsigned DEPTH      = 4096;
    localparam int unsigned RATE       = 48000;
    localparam int unsigned NUM_TAPS   = 19;
    // total stimulus the random segments fill up to, directed part included, in samples
    localparam int unsigned STIM_TOTAL = 700;
    localparam int unsigned CALM_TAIL  = 300;
    localparam int unsigned QUIET_MAX  = 2000;

    // reflection times in units of 10 us
    localparam int unsigned REFL_TIME [NUM_TAPS] = '{
        0, 1277, 1283, 1293, 1333, 1566, 2404, 2679, 2731, 2737,
        2914, 2920, 2981, 3389, 4518, 4522, 4527, 5452, 6958
    };

    // tap weights, signed Q2.15
    localparam int REFL_GAIN [NUM_TAPS] = '{
        32768, 5000, -13425, 9778, 5089, 4725, -10237, -13684, -30772, 22695,
        -18963, 18946, 13782, 12970, 11305, -17567, 13664, 6383, 5072
    };

    // hand-picked samples: extremes, bit patterns, near-zero values
    localparam int DIRECTED [20] = '{
        0, 32767, -32768, 1, -1, 21845, -21846, 16384, -16384, 32767,
        32767, 32767, -32768, -32768, -32768, 0, 12345, -12345, 255, -256
    };

    typedef enum int {
        SEG_NOISE,
        SEG_EXTREME,
        SEG_QUIET,
        SEG_STEADY,
        SEG_SPARSE
    } t_seg_kind;

    typedef enum int {
        IDLE_NONE,
        IDLE_LIGHT,
        IDLE_HEAVY
    } t_idle_mode;

    typedef struct {
        logic signed [15:0] sample;
        bit                 hold_for_drain;
    } t_sample_item;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [15:0] i_sample_in = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [15:0] o_reflection_out;

    // predictor state
    logic signed [15:0] echo_mem [DEPTH];
    logic [11:0]        wr_ptr;
    int unsigned        tap_lag [NUM_TAPS];

    t_sample_item       sample_backlog [$];
    logic signed [15:0] reflection_due [$];

    bit                 in_beat = 1'b0;
    int                 mismatch_count = 0;
    int unsigned        quiet_cycles = 0;
    int                 send_gap = 0;
    int                 take_gap = 0;
    t_idle_mode         send_mode = IDLE_LIGHT;
    t_idle_mode         take_mode = IDLE_LIGHT;

    early_reflection_tapped_delay #(
        .DELAY_DEPTH (DEPTH),
        .SAMPLE_RATE (RATE)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_sample_in      (i_sample_in),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_reflection_out (o_reflection_out)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // tap delay in samples, rounded half up, clipped to the memory size
    function automatic int unsigned reflection_lag(int unsigned t10us);
        longint unsigned d;
        d = RATE;
        d = (d * t10us + 50000) / 100000;
        if (d > DEPTH - 1) begin
            d = DEPTH - 1;
        end
        return int'(d);
    endfunction

    // write the sample, sum the weighted taps, round and saturate to 16 bits
    function automatic logic signed [15:0] reflect_sample(logic signed [15:0] s);
        longint      acc;
        longint      y;
        logic [11:0] rd;
        int          k;
        echo_mem[wr_ptr] = s;
        acc = 0;
        for (k = 0; k < NUM_TAPS; k++) begin
            rd = wr_ptr - 12'(tap_lag[k]);
            acc += longint'(echo_mem[rd]) * longint'(REFL_GAIN[k]);
        end
        y = (acc + 16384) >>> 15;
        if (y > 32767) begin
            y = 32767;
        end
        if (y < -32768) begin
            y = -32768;
        end
        wr_ptr = wr_ptr + 12'd1;
        return 16'(y);
    endfunction

    function automatic void queue_sample(logic signed [15:0] s, bit hold);
        t_sample_item it;
        it.sample         = s;
        it.hold_for_drain = hold;
        sample_backlog.push_back(it);
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // accepted input beats go through the predictor, output beats are checked
    always @(posedge i_clk) begin
        logic signed [15:0] want;
        in_beat <= i_rst_n && i_valid && o_ready;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                reflection_due.push_back(reflect_sample(i_sample_in));
            end
            if (o_valid && i_ready) begin
                if (reflection_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected reflection_out %0d",
                                              o_reflection_out));
                end else begin
                    want = reflection_due.pop_front();
                    if (o_reflection_out !== want) begin
                        report_mismatch($sformatf("reflection_out %0d, expected %0d",
                                                  o_reflection_out, want));
                    end
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_MAX) begin
            $display("watchdog: no beat for %0d cycles", QUIET_MAX);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // sample driver with random gaps and optional drain before an item
    always @(negedge i_clk) begin
        logic               nxt_valid;
        logic signed [15:0] nxt_sample;
        t_sample_item       it;
        nxt_valid  = i_valid;
        nxt_sample = i_sample_in;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if ($urandom_range(0, 149) == 0) begin
                send_mode = t_idle_mode'($urandom_range(0, 2));
            end
            if (in_beat) begin
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (send_gap != 0) begin
                    send_gap--;
                end else if (sample_backlog.size() != 0) begin
                    if (sample_backlog[0].hold_for_drain && reflection_due.size() != 0) begin
                        // wait for the pipeline to empty
                    end else if (sample_backlog.size() > CALM_TAIL && send_mode != IDLE_NONE &&
                                 $urandom_range(0, send_mode == IDLE_LIGHT ? 15 : 2) == 0) begin
                        send_gap = $urandom_range(0, 13);
                    end else begin
                        it         = sample_backlog.pop_front();
                        nxt_valid  = 1'b1;
                        nxt_sample = it.sample;
                    end
                end
            end
        end
        i_valid     <= nxt_valid;
        i_sample_in <= nxt_sample;
    end

    // receiver with random stall bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 149) == 0) begin
                take_mode = t_idle_mode'($urandom_range(0, 2));
            end
            if (take_gap != 0) begin
                take_gap--;
                i_ready <= 1'b0;
            end else if (sample_backlog.size() > CALM_TAIL && take_mode != IDLE_NONE &&
                         $urandom_range(0, take_mode == IDLE_LIGHT ? 24 : 4) == 0) begin
                take_gap = $urandom_range(0, 13);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        t_seg_kind          seg_kind;
        int                 seg_len;
        int                 n;
        logic signed [15:0] v;
        logic signed [15:0] level;

        // predictor reset state
        for (n = 0; n < DEPTH; n++) begin
            echo_mem[n] = '0;
        end
        wr_ptr = '0;
        for (n = 0; n < NUM_TAPS; n++) begin
            tap_lag[n] = reflection_lag(REFL_TIME[n]);
        end

        // directed: extremes and patterns while only the zero-delay tap sees data
        for (n = 0; n < 20; n++) begin
            queue_sample(16'(DIRECTED[n]), n == 10);
        end

        // random segments of well-formed signal shapes, some behind a drain
        n = 0;
        while (sample_backlog.size() < STIM_TOTAL) begin
            seg_kind = t_seg_kind'($urandom_range(0, 4));
            seg_len  = $urandom_range(16, 100);
            level    = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000)
                                            : 16'($urandom);
            for (int j = 0; j < seg_len; j++) begin
                case (seg_kind)
                    SEG_NOISE: begin
                        v = 16'($urandom);
                    end
                    SEG_EXTREME: begin
                        v = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                    end
                    SEG_QUIET: begin
                        v = 16'(int'($urandom_range(0, 511)) - 256);
                    end
                    SEG_STEADY: begin
                        v = level;
                    end
                    default: begin
                        v = ($urandom_range(0, 63) == 0) ? 16'($urandom) : 16'sd0;
                    end
                endcase
                queue_sample(v, (n == 0) || (j == 0 && $urandom_range(0, 5) == 0));
                n++;
            end
        end

        // single reset at the start
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (sample_backlog.size() != 0 || i_valid) begin
            @(posedge i_clk);
        end
        while (reflection_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (60) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
